>>> rtl/core/sfdq_pkg.sv
// Shared types and constants for the signal filter with deferred queue.
// No dependencies; imported by the controller, the datapath and the top level.
package sfdq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int SIGNAL_COUNT = 32;

    localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
    localparam int SIG_W     = 5;
    localparam int SIG_EXT_W = SIG_W + 1;
    localparam int MASK_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [QIDX_W-1:0]    QUEUE_LAST = QIDX_W'(QUEUE_DEPTH - 1);
    localparam logic [SIG_EXT_W-1:0] SIG_LIMIT  = SIG_EXT_W'(SIGNAL_COUNT);

    localparam logic [MASK_W-1:0] DANGEROUS_RESET = 32'h0000_0890;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DANGEROUS = 2'd2;

    typedef enum logic [2:0] {
        ACT_IGNORED   = 3'd0,
        ACT_HANDLER   = 3'd1,
        ACT_EXCEPTION = 3'd2,
        ACT_QUEUED    = 3'd3,
        ACT_DUPLICATE = 3'd4,
        ACT_HARMFUL   = 3'd5,
        ACT_OVERFLOW  = 3'd6,
        ACT_EMPTY     = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

>>> rtl/core/signal_filter_deferred_queue.sv
// Top level of the signal filter with deferred ring queue.
// Depends on sfdq_pkg, sfdq_ctrl and sfdq_datapath.

// Each input transfer is a signal arrival (s_tuser = 0) or a dispatch request
// (s_tuser = 1) and yields exactly one result transfer carrying an action code,
// the signal it concerns and the pending flag after the step. The item is
// captured at its accepting edge and executed at the next edge (a single
// queue-store access plus the mask checks, sequenced by the control state
// machine), which also loads the result register; the result is offered from
// then on, so the result transfer follows acceptance through the EXEC and OUT
// states. The next item is accepted in the cycle after the result transfer
// completes, so no new item is taken while a result waits, and an output
// stall holds back the next item. The queue holds up to QUEUE_DEPTH - 1 signals
// and is cleared at reset in the same cycle, with no clearing pass. Write the
// three mask registers (ignore, handler, dangerous) through cfg_we only while
// the block is idle; the dangerous mask resets to signals 4, 7 and 11.
module signal_filter_deferred_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [4:0] sig_number, [5] blocked, [7:6] zero
    input  logic                           s_tuser,  // [0] func
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // [4:0] sig_out, [5] pending, [7:6] zero
    output logic [2:0]                     m_tuser,  // [2:0] action
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [sfdq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfdq_pkg::MASK_W-1:0]    cfg_data
);
    import sfdq_pkg::*;

    ctrl_cmd_t        cmd;
    action_t          out_action;
    logic [SIG_W-1:0] out_sig;
    logic             out_pending;

    // Sequence handshake and execute step
    sfdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Hold masks, queue and result
    sfdq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_func     (s_tuser),
        .in_sig      (s_tdata[SIG_W-1:0]),
        .in_blocked  (s_tdata[SIG_W]),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_action  (out_action),
        .out_sig     (out_sig),
        .out_pending (out_pending)
    );

    assign m_tdata = {2'b00, out_pending, out_sig};
    assign m_tuser = out_action;

    // Input and output sides are never open at the same time
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // An accepted transfer passes through the execute step and then offers a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (cmd.execute && !s_tready) ##1 m_tvalid)
        else $error("result did not follow accepted transfer");

    // Empty dispatch reports no signal and clears pending
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ACT_EMPTY) |-> (m_tdata[5:0] == 6'd0))
        else $error("empty result carries a signal or pending");

    // A queued signal always leaves pending set
    a_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ACT_QUEUED) |-> m_tdata[5])
        else $error("queued result without pending");

endmodule

>>> rtl/core/sfdq_ctrl.sv
// Sequencer for the signal filter: input handshake, execute step, result hold.
// Depends on sfdq_pkg (state_t, ctrl_cmd_t).
module sfdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output sfdq_pkg::ctrl_cmd_t cmd
);
    import sfdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/sfdq_datapath.sv
// Datapath: mask registers, ring queue store and indexes, decision logic, result register.
// Depends on sfdq_pkg (widths, action codes, register indexes, ctrl_cmd_t).
module sfdq_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sfdq_pkg::ctrl_cmd_t                cmd,
    input  logic                               in_func,
    input  logic [sfdq_pkg::SIG_W-1:0]         in_sig,
    input  logic                               in_blocked,
    input  logic                               cfg_we,
    input  logic [sfdq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfdq_pkg::MASK_W-1:0]        cfg_data,
    output sfdq_pkg::action_t                  out_action,
    output logic [sfdq_pkg::SIG_W-1:0]         out_sig,
    output logic                               out_pending
);
    import sfdq_pkg::*;

    logic [MASK_W-1:0] ignore_reg;
    logic [MASK_W-1:0] handler_reg;
    logic [MASK_W-1:0] dangerous_reg;

    logic              func_reg;
    logic [SIG_W-1:0]  sig_reg;
    logic              blocked_reg;

    logic [SIG_W-1:0]  queue_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_idx_reg;
    logic [QIDX_W-1:0] wr_idx_next;
    logic [QIDX_W-1:0] rd_idx_reg;
    logic [QIDX_W-1:0] rd_idx_next;
    logic              pending_reg;
    logic              pending_next;

    action_t           action_reg;
    action_t           action_next;
    logic [SIG_W-1:0]  sig_out_reg;
    logic [SIG_W-1:0]  sig_out_next;
    logic              pend_out_reg;

    logic [QIDX_W-1:0] pos;
    logic [QIDX_W-1:0] last;
    logic [QIDX_W-1:0] wr_idx_inc;
    logic [QIDX_W-1:0] rd_addr;
    logic [SIG_W-1:0]  rd_data;
    logic              q_wr_en;
    logic [QIDX_W-1:0] q_wr_addr;
    logic [SIG_W-1:0]  q_wr_val;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_reg    <= '0;
            handler_reg   <= '0;
            dangerous_reg <= DANGEROUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IGNORE:    ignore_reg    <= cfg_data;
                CFG_HANDLER:   handler_reg   <= cfg_data;
                CFG_DANGEROUS: dangerous_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= in_func;
            sig_reg     <= in_sig;
            blocked_reg <= in_blocked;
        end
    end

    assign pos        = (rd_idx_reg == QUEUE_LAST) ? '0 : rd_idx_reg + 1'b1;
    assign wr_idx_inc = (wr_idx_reg == QUEUE_LAST) ? '0 : wr_idx_reg + 1'b1;
    assign last       = (wr_idx_reg == '0) ? QUEUE_LAST : wr_idx_reg - 1'b1;

    // Single read port: dispatch reads the head, arrival reads the newest entry
    assign rd_addr = func_reg ? pos : last;
    assign rd_data = queue_reg[rd_addr];

    always_comb
    begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        pending_next = pending_reg;
        action_next  = ACT_IGNORED;
        sig_out_next = sig_reg;
        q_wr_en      = 1'b0;
        q_wr_addr    = wr_idx_reg;
        q_wr_val     = sig_reg;
        if (func_reg)
        begin
            if (pos == wr_idx_reg)
            begin
                pending_next = 1'b0;
                action_next  = ACT_EMPTY;
                sig_out_next = '0;
            end
            else
            begin
                rd_idx_next  = pos;
                sig_out_next = rd_data;
                q_wr_en      = 1'b1;
                q_wr_addr    = pos;
                q_wr_val     = '0;
                action_next  = handler_reg[rd_data] ? ACT_HANDLER : ACT_EXCEPTION;
            end
        end
        else if (sig_reg == '0 || {1'b0, sig_reg} >= SIG_LIMIT || ignore_reg[sig_reg])
        begin
            action_next = ACT_IGNORED;
        end
        else if (!blocked_reg)
        begin
            action_next = handler_reg[sig_reg] ? ACT_HANDLER : ACT_EXCEPTION;
        end
        else if (dangerous_reg[sig_reg])
        begin
            action_next = ACT_HARMFUL;
        end
        else if (wr_idx_reg == rd_idx_reg)
        begin
            action_next = ACT_OVERFLOW;
        end
        else if (rd_data == sig_reg)
        begin
            action_next = ACT_DUPLICATE;
        end
        else
        begin
            q_wr_en      = 1'b1;
            wr_idx_next  = wr_idx_inc;
            pending_next = 1'b1;
            action_next  = ACT_QUEUED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= QUEUE_LAST;
            pending_reg <= 1'b0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                queue_reg[i] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            pending_reg <= pending_next;
            if (q_wr_en)
            begin
                queue_reg[q_wr_addr] <= q_wr_val;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            action_reg   <= action_next;
            sig_out_reg  <= sig_out_next;
            pend_out_reg <= pending_next;
        end
    end

    assign out_action  = action_reg;
    assign out_sig     = sig_out_reg;
    assign out_pending = pend_out_reg;

endmodule
